[rtl/core/bmfs_pkg.sv]
// ----------------------------------------------------------------------------
// bmfs_pkg
// Shared types and codes for the biased matrix factorization trainer.
// ----------------------------------------------------------------------------
package bmfs_pkg;

  // Operation carried by an input transfer
  typedef enum logic [2:0] {
    MODE_TRAIN    = 3'd0,
    MODE_PREDICT  = 3'd1,
    MODE_WR_UF    = 3'd2,
    MODE_WR_IF    = 3'd3,
    MODE_WR_UB    = 3'd4,
    MODE_WR_IB    = 3'd5,
    MODE_WR_AVG   = 3'd6,
    MODE_NOP      = 3'd7
  } bmfs_mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_REG_WEIGHT = 2'd1,
    CFG_RATINGS    = 2'd2,
    CFG_FACTORS    = 2'd3
  } bmfs_cfg_e;

  localparam int unsigned ValW = 32;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [ValW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[ValW-1:0];
    end
  endfunction

endpackage

[rtl/core/bmfs_ram.sv]
// ----------------------------------------------------------------------------
// bmfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/biased_matrix_factorize_sgd_top.sv]
// ----------------------------------------------------------------------------
// biased_matrix_factorize_sgd_top
// SGD trainer and predictor for a biased matrix factorization model.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                       payload
//  s_axis    in    s_axis_tvalid_i/s_axis_tready_o  mode,user,item,rating,slot,load
//  m_axis    out   m_axis_tvalid_o/m_axis_tready_i  prediction,rounded,residual
//  cfg       in    cfg_we_i (no wait)               cfg_idx_i, cfg_wdata_i
//
// One item at a time. Indexes are reduced by shifted compares, the dot product
// runs one factor after another, the rate is divided by a restoring divider,
// and each update runs through the shared 32x32 multiplier. Reset clears
// control state, loads the configuration defaults and clears the average and
// the step count; table contents are undefined until written. A stalled
// output holds the finished result; the next item is taken once the block is
// idle.
// ----------------------------------------------------------------------------
module biased_matrix_factorize_sgd_top
  import bmfs_pkg::*;
#(
  parameter int unsigned MAX_USERS   = 1024,
  parameter int unsigned MAX_ITEMS   = 2048,
  parameter int unsigned MAX_FACTORS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // mode[2:0], user[12:3], item[23:13], rating[27:24], factor_slot[31:28],
  // load_value[63:32]
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // prediction[31:0], rounded_rating[35:32], residual[67:36], zero[71:68]
  output logic [71:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);

  localparam int unsigned UIW   = $clog2(MAX_USERS);
  localparam int unsigned IIW   = $clog2(MAX_ITEMS);
  localparam int unsigned UFD   = MAX_USERS * MAX_FACTORS;
  localparam int unsigned IFD   = MAX_ITEMS * MAX_FACTORS;
  localparam int unsigned UFW   = $clog2(UFD);
  localparam int unsigned IFW   = $clog2(IFD);
  localparam int unsigned KW    = $clog2(MAX_FACTORS + 1);
  localparam int unsigned KIW   = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int unsigned DIVN  = 55;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX, ST_BIAS_RD, ST_BIAS_WT, ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC,
    ST_PRED, ST_RATE_MUL, ST_RATE_LD, ST_RATE_DIV, ST_UPD, ST_WRITE, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    TG_USER, TG_ITEM, TG_AVG, TG_UB, TG_IB
  } target_e;

  // Fixed-point product: round half up, floor shift
  function automatic logic signed [63:0] mulq(input logic signed [63:0] p);
    mulq = (p + HALF) >>> FRAC_BITS;
  endfunction

  // Configuration
  logic [30:0] learn_rate_q, reg_weight_q;
  logic [23:0] ratings_q;
  logic [4:0]  factors_q;

  // Control
  state_e      state_q;
  target_e     tgt_q;
  logic [2:0]  ph_q;
  logic [3:0]  sh_q;
  logic [KW-1:0] k_q;
  logic [5:0]  div_cnt_q;
  bmfs_mode_e  mode_q;
  logic        m_valid_q;

  // Datapath
  logic [9:0]  rem_u_q;
  logic [10:0] rem_i_q;
  logic [3:0]  rating_q, slot_q;
  logic signed [31:0] load_q, avg_q, ub_q, ib_q, e_q, g_q, pred_q, res_q;
  logic [3:0]  rnd_q;
  logic signed [63:0] acc_q, t1_q;
  logic [31:0] step_q;
  logic [54:0] num_q;
  logic [32:0] rem_q, den_q;
  logic [71:0] out_q;
  logic signed [31:0] u_row [MAX_FACTORS];
  logic signed [31:0] v_row [MAX_FACTORS];
  logic signed [63:0] prod_q;

  // Derived values
  logic [6:0]     nf_wide;
  logic [KW-1:0]  nf;
  logic [23:0]    n_eff;
  logic [UIW-1:0] u_idx;
  logic [IIW-1:0] i_idx;
  logic [UFW-1:0] uf_addr;
  logic [IFW-1:0] if_addr;
  logic [KW-1:0]  kslot;
  logic [KIW-1:0] ki;
  logic [27:0]    dm_u, dm_i;
  logic signed [31:0] uf_rd, if_rd, ub_rd, ib_rd;
  logic signed [31:0] mul_a, mul_b, x_sel, a_sel, new_x;
  logic           slot_ok;
  logic           uf_we, if_we, ub_we, ib_we;
  logic signed [31:0] uf_wd, if_wd, ub_wd, ib_wd;
  logic [32:0]    rem_t_w;
  logic [33:0]    rem_t;

  assign nf_wide = (7'(factors_q) > 7'(MAX_FACTORS)) ? 7'(MAX_FACTORS) : 7'(factors_q);
  assign nf      = KW'(nf_wide);
  assign n_eff   = (ratings_q == 24'd0) ? 24'd1 : ratings_q;
  assign u_idx   = UIW'(rem_u_q);
  assign i_idx   = IIW'(rem_i_q);
  assign slot_ok = 7'(slot_q) < 7'(MAX_FACTORS);
  assign kslot   = (state_q == ST_WRITE) ? KW'(slot_q) : k_q;
  assign ki      = KIW'(k_q);
  assign uf_addr = UFW'(rem_u_q) * UFW'(MAX_FACTORS) + UFW'(kslot);
  assign if_addr = IFW'(rem_i_q) * IFW'(MAX_FACTORS) + IFW'(kslot);
  assign dm_u    = 28'(MAX_USERS) << sh_q;
  assign dm_i    = 28'(MAX_ITEMS) << sh_q;
  assign rem_t   = {rem_q, num_q[54]};
  assign rem_t_w = rem_t[32:0] - den_q;

  // Select the operand being updated and its partner
  always_comb begin
    x_sel = avg_q;
    a_sel = 32'sd0;
    case (tgt_q)
      TG_USER: begin x_sel = u_row[ki]; a_sel = v_row[ki]; end
      TG_ITEM: begin x_sel = v_row[ki]; a_sel = u_row[ki]; end
      TG_AVG:  x_sel = avg_q;
      TG_UB:   x_sel = ub_q;
      TG_IB:   x_sel = ib_q;
      default: x_sel = avg_q;
    endcase
  end

  assign new_x = sat32(64'(x_sel) + mulq(prod_q));

  // Shared multiplier operand selection
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state_q)
      ST_DOT_MUL:  begin mul_a = uf_rd; mul_b = if_rd; end
      ST_RATE_MUL: begin mul_a = {1'b0, learn_rate_q}; mul_b = {8'd0, n_eff}; end
      ST_UPD: begin
        case (ph_q)
          3'd0:    begin mul_a = e_q; mul_b = a_sel; end
          3'd1:    begin mul_a = {1'b0, reg_weight_q}; mul_b = x_sel; end
          3'd3:    begin mul_a = num_q[31:0]; mul_b = g_q; end
          default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
        endcase
      end
      default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
    endcase
  end

  // Table write strobes
  always_comb begin
    uf_we = 1'b0; if_we = 1'b0; ub_we = 1'b0; ib_we = 1'b0;
    uf_wd = load_q; if_wd = load_q; ub_wd = load_q; ib_wd = load_q;
    if (state_q == ST_WRITE) begin
      uf_we = (mode_q == MODE_WR_UF) && slot_ok;
      if_we = (mode_q == MODE_WR_IF) && slot_ok;
      ub_we = (mode_q == MODE_WR_UB);
      ib_we = (mode_q == MODE_WR_IB);
    end else if (state_q == ST_UPD && ph_q == 3'd4) begin
      uf_we = (tgt_q == TG_USER);
      if_we = (tgt_q == TG_ITEM);
      ub_we = (tgt_q == TG_UB);
      ib_we = (tgt_q == TG_IB);
      uf_wd = new_x; if_wd = new_x; ub_wd = new_x; ib_wd = new_x;
    end
  end

  bmfs_ram #(.WIDTH(32), .DEPTH(UFD)) u_uf_ram (
    .clk_i, .we_i(uf_we), .waddr_i(uf_addr), .wdata_i(uf_wd),
    .raddr_i(uf_addr), .rdata_o(uf_rd)
  );
  bmfs_ram #(.WIDTH(32), .DEPTH(IFD)) u_if_ram (
    .clk_i, .we_i(if_we), .waddr_i(if_addr), .wdata_i(if_wd),
    .raddr_i(if_addr), .rdata_o(if_rd)
  );
  bmfs_ram #(.WIDTH(32), .DEPTH(MAX_USERS)) u_ub_ram (
    .clk_i, .we_i(ub_we), .waddr_i(u_idx), .wdata_i(ub_wd),
    .raddr_i(u_idx), .rdata_o(ub_rd)
  );
  bmfs_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_ib_ram (
    .clk_i, .we_i(ib_we), .waddr_i(i_idx), .wdata_i(ib_wd),
    .raddr_i(i_idx), .rdata_o(ib_rd)
  );

  // Product register and local copies of the factor rows
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_DOT_MUL) begin
      u_row[ki] <= uf_rd;
      v_row[ki] <= if_rd;
    end else if (state_q == ST_UPD && ph_q == 3'd4) begin
      if (tgt_q == TG_USER) u_row[ki] <= new_x;
      if (tgt_q == TG_ITEM) v_row[ki] <= new_x;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tgt_q        <= TG_USER;
      ph_q         <= 3'd0;
      sh_q         <= 4'd0;
      k_q          <= '0;
      div_cnt_q    <= 6'd0;
      mode_q       <= MODE_NOP;
      m_valid_q    <= 1'b0;
      learn_rate_q <= 31'd655;
      reg_weight_q <= 31'd655;
      ratings_q    <= 24'd100000;
      factors_q    <= 5'd16;
      avg_q        <= 32'sd0;
      step_q       <= 32'd0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (bmfs_cfg_e'(cfg_idx_i))
          CFG_LEARN_RATE: learn_rate_q <= cfg_wdata_i;
          CFG_REG_WEIGHT: reg_weight_q <= cfg_wdata_i;
          CFG_RATINGS:    ratings_q    <= cfg_wdata_i[23:0];
          CFG_FACTORS:    factors_q    <= cfg_wdata_i[4:0];
          default:        ;
        endcase
      end

      // raise valid for a finished item, drop it once the transfer completes
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            mode_q   <= bmfs_mode_e'(s_axis_tdata_i[2:0]);
            rem_u_q  <= s_axis_tdata_i[12:3];
            rem_i_q  <= s_axis_tdata_i[23:13];
            rating_q <= s_axis_tdata_i[27:24];
            slot_q   <= s_axis_tdata_i[31:28];
            load_q   <= s_axis_tdata_i[63:32];
            pred_q   <= 32'sd0;
            res_q    <= 32'sd0;
            rnd_q    <= 4'd0;
            sh_q     <= 4'd11;
            state_q  <= ST_IDX;
          end
        end
        // reduce indexes modulo the table sizes, one shifted compare per cycle
        ST_IDX: begin
          if (28'(rem_u_q) >= dm_u) rem_u_q <= rem_u_q - dm_u[9:0];
          if (28'(rem_i_q) >= dm_i) rem_i_q <= rem_i_q - dm_i[10:0];
          sh_q <= sh_q - 4'd1;
          if (sh_q == 4'd0) begin
            state_q <= (mode_q == MODE_TRAIN || mode_q == MODE_PREDICT) ?
                       ST_BIAS_RD : ST_WRITE;
          end
        end
        ST_BIAS_RD: state_q <= ST_BIAS_WT;
        ST_BIAS_WT: begin
          ub_q    <= ub_rd;
          ib_q    <= ib_rd;
          acc_q   <= 64'(avg_q) + 64'(ub_rd) + 64'(ib_rd);
          k_q     <= '0;
          state_q <= (nf == '0) ? ST_PRED : ST_DOT_RD;
        end
        ST_DOT_RD:  state_q <= ST_DOT_MUL;
        ST_DOT_MUL: state_q <= ST_DOT_ACC;
        ST_DOT_ACC: begin
          acc_q   <= acc_q + mulq(prod_q);
          k_q     <= k_q + 1'b1;
          state_q <= (k_q + 1'b1 == nf) ? ST_PRED : ST_DOT_RD;
        end
        // prediction, residual and rounded rating
        ST_PRED: begin
          pred_q <= sat32(acc_q);
          res_q  <= sat32((64'(rating_q) <<< FRAC_BITS) - 64'(sat32(acc_q)));
          e_q    <= sat32((64'(rating_q) <<< FRAC_BITS) - 64'(sat32(acc_q)));
          if (sat32(acc_q) < 0) begin
            rnd_q <= 4'd0;
          end else if (mulq(64'(sat32(acc_q))) > 64'sd15) begin
            rnd_q <= 4'd15;
          end else begin
            rnd_q <= 4'(mulq(64'(sat32(acc_q))));
          end
          if (mode_q == MODE_TRAIN) begin
            if (step_q != '1) step_q <= step_q + 32'd1;
            state_q <= ST_RATE_MUL;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_RATE_MUL: state_q <= ST_RATE_LD;
        ST_RATE_LD: begin
          num_q     <= prod_q[54:0];
          rem_q     <= '0;
          den_q     <= 33'(n_eff) + 33'(step_q);
          div_cnt_q <= 6'd0;
          state_q   <= ST_RATE_DIV;
        end
        // restoring divide, one quotient bit per cycle
        ST_RATE_DIV: begin
          if (rem_t >= 34'(den_q)) begin
            rem_q <= rem_t_w;
            num_q <= {num_q[53:0], 1'b1};
          end else begin
            rem_q <= rem_t[32:0];
            num_q <= {num_q[53:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(DIVN - 1)) begin
            k_q     <= '0;
            ph_q    <= 3'd0;
            tgt_q   <= (nf == '0) ? TG_AVG : TG_USER;
            state_q <= ST_UPD;
          end
        end
        // five-phase update of one value through the shared multiplier
        ST_UPD: begin
          case (ph_q)
            3'd1: t1_q <= (tgt_q == TG_USER || tgt_q == TG_ITEM) ?
                          mulq(prod_q) : 64'(e_q);
            3'd2: g_q <= (tgt_q == TG_AVG) ? e_q : sat32(t1_q - mulq(prod_q));
            default: ;
          endcase
          if (ph_q == 3'd4) begin
            ph_q <= 3'd0;
            case (tgt_q)
              TG_USER, TG_ITEM: begin
                if (k_q + 1'b1 == nf) begin
                  k_q   <= '0;
                  tgt_q <= (tgt_q == TG_USER) ? TG_ITEM : TG_AVG;
                end else begin
                  k_q <= k_q + 1'b1;
                end
              end
              TG_AVG: begin
                avg_q <= new_x;
                tgt_q <= TG_UB;
              end
              TG_UB:   tgt_q <= TG_IB;
              default: state_q <= ST_DONE;
            endcase
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_WRITE: begin
          if (mode_q == MODE_WR_AVG) avg_q <= load_q;
          state_q <= ST_DONE;
        end
        // hand the result to the output register
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            out_q     <= {4'd0, res_q, rnd_q, pred_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Divider never runs past its last quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RATE_DIV) |-> (div_cnt_q < 6'(DIVN)))
    else $error("divider step count overrun");

  // Decayed rate never exceeds the base rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && tgt_q == TG_AVG) |-> (num_q <= 55'(learn_rate_q)))
    else $error("decayed rate above base rate");

  // Factor loop index stays below the factor count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOT_MUL) |-> (k_q < nf))
    else $error("factor index out of range");

endmodule

[dv/biased_matrix_factorize_sgd_top_test.sv]
// ----------------------------------------------------------------------------
// biased_matrix_factorize_sgd_top_test
// Self-checking bench for the SGD trainer: a directed table, then random
// mixed-mode traffic over a small pool of initialized users and items,
// checked against a bit-level predictor. Bursty input, patterned output stalls.
// ----------------------------------------------------------------------------
module biased_matrix_factorize_sgd_top_test
  import bmfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NU = 1024;
  localparam int NI = 2048;
  localparam int NF = 16;
  localparam int FB = 16;

  // Packed from the most significant field down: prediction sits lowest
  typedef struct packed {
    logic [31:0] res;
    logic [3:0]  rnd;
    logic [31:0] pred;
  } rating_out_t;

  typedef struct {
    bmfs_mode_e  mode;
    logic [9:0]  user;
    logic [10:0] item;
    logic [3:0]  rating;
    logic [3:0]  slot;
    logic [31:0] lv;
    bit          known;
    rating_out_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_wdata_i = '0;

  biased_matrix_factorize_sgd_top uut (.*);

  // Predictor state
  longint      eta, lam, npass, nfac;
  int          uf_tab [NU*NF];
  int          if_tab [NI*NF];
  int          ub_tab [NU];
  int          ib_tab [NI];
  int          avg;
  int unsigned steps;

  rating_out_t pending_ratings[$];
  int          errors = 0;
  bit          hold_off = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat_wide(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Round half up, then floor shift (arithmetic shift is floor)
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << (FB - 1))) >>> FB;
  endfunction

  function automatic int step_to(longint x, longint g, longint r);
    return int'(sat_wide(x + qmul(r, sat_wide(g))));
  endfunction

  function automatic rating_out_t compute_rating(stim_row_t s);
    rating_out_t o;
    longint acc, p, e, r, n, a, b;
    int     ui, ii, k, nf;
    o = '0;
    ui = s.user;
    ii = s.item;
    nf = (nfac > NF) ? NF : int'(nfac);
    if (s.mode == MODE_TRAIN || s.mode == MODE_PREDICT) begin
      acc = longint'(avg) + ub_tab[ui] + ib_tab[ii];
      for (k = 0; k < nf; k++) acc += qmul(uf_tab[ui*NF+k], if_tab[ii*NF+k]);
      p = sat_wide(acc);
      e = sat_wide((longint'(s.rating) << FB) - p);
      o.pred = p[31:0];
      o.res = e[31:0];
      if (p >= 0) begin
        r = (p + (64'sd1 << (FB - 1))) >>> FB;
        o.rnd = (r > 15) ? 4'd15 : r[3:0];
      end
      if (s.mode == MODE_TRAIN) begin
        n = (npass == 0) ? 1 : npass;
        if (steps != 32'hFFFFFFFF) steps++;
        r = (eta * n) / (n + longint'(steps));
        for (k = 0; k < nf; k++) begin
          a = uf_tab[ui*NF+k];
          b = if_tab[ii*NF+k];
          uf_tab[ui*NF+k] = step_to(a, qmul(e, b) - qmul(lam, a), r);
        end
        for (k = 0; k < nf; k++) begin
          a = uf_tab[ui*NF+k];
          b = if_tab[ii*NF+k];
          if_tab[ii*NF+k] = step_to(b, qmul(e, a) - qmul(lam, b), r);
        end
        avg = step_to(avg, e, r);
        ub_tab[ui] = step_to(ub_tab[ui], e - qmul(lam, ub_tab[ui]), r);
        ib_tab[ii] = step_to(ib_tab[ii], e - qmul(lam, ib_tab[ii]), r);
      end
    end else begin
      case (s.mode)
        MODE_WR_UF: uf_tab[ui*NF+s.slot] = s.lv;
        MODE_WR_IF: if_tab[ii*NF+s.slot] = s.lv;
        MODE_WR_UB: ub_tab[ui] = s.lv;
        MODE_WR_IB: ib_tab[ii] = s.lv;
        MODE_WR_AVG: avg = s.lv;
        default: ;
      endcase
    end
    return o;
  endfunction

  // Receiver: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    rating_out_t got, w;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[67:0];
      if (pending_ratings.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        w = pending_ratings.pop_front();
        if (got !== w || m_axis_tdata_o[71:68] !== 4'd0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch pred %h/%h rnd %0d/%0d res %h/%h", w.pred, got.pred,
                     w.rnd, got.rnd, w.res, got.res);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int c;
    c = 0;
    forever begin
      @(negedge clk_i);
      c++;
      if (hold_off) m_axis_tready_i <= 1'b0;
      else if (c % 512 < 128) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(stim_row_t s);
    rating_out_t w;
    w = compute_rating(s);
    if (s.known && w !== s.want) begin
      errors++;
      if (errors <= 10) $display("table row disagrees: %h vs %h", s.want, w);
    end
    pending_ratings = {pending_ratings, w};
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {s.lv, s.slot, s.rating, s.item, s.user, s.mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Sender gap between bursts
  int burst_left = 0;
  task automatic send_paced(stim_row_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(s);
  endtask

  task automatic drain_and_wait();
    int guard;
    s_axis_tvalid_i <= 1'b0;
    guard = 0;
    while (pending_ratings.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (300) @(negedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_cfg(bmfs_cfg_e idx, logic [30:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    case (idx)
      CFG_LEARN_RATE: eta = v;
      CFG_REG_WEIGHT: lam = v;
      CFG_RATINGS: npass = v[23:0];
      default: nfac = v[4:0];
    endcase
  endtask

  function automatic stim_row_t mk(bmfs_mode_e m, int u, int i, int r, int sl,
                                   logic [31:0] lv);
    stim_row_t s;
    s.mode = m; s.user = 10'(u); s.item = 11'(i); s.rating = 4'(r); s.slot = 4'(sl);
    s.lv = lv;
    s.known = 0; s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t mkw(stim_row_t s, logic [31:0] p, int r, logic [31:0] e);
    s.known = 1; s.want.pred = p; s.want.rnd = 4'(r); s.want.res = e;
    return s;
  endfunction

  // Initialize one user or item entry fully
  task automatic load_user(int u, int span);
    int k;
    for (k = 0; k < NF; k++)
      send_paced(mk(MODE_WR_UF, u, 0, 0, k, $urandom_range(0, 2*span) - span));
    send_paced(mk(MODE_WR_UB, u, 0, 0, 0, $urandom_range(0, 2*span) - span));
  endtask

  task automatic load_item(int i, int span);
    int k;
    for (k = 0; k < NF; k++)
      send_paced(mk(MODE_WR_IF, 0, i, 0, k, $urandom_range(0, 2*span) - span));
    send_paced(mk(MODE_WR_IB, 0, i, 0, 0, $urandom_range(0, 2*span) - span));
  endtask

  int users[$];
  int items[$];

  initial begin
    stim_row_t table_rows[$];
    stim_row_t s;
    int n, k, ph, sent;
    eta = 655; lam = 655; npass = 100000; nfac = 16; avg = 0; steps = 0;
    foreach (uf_tab[k]) uf_tab[k] = 0;
    foreach (if_tab[k]) if_tab[k] = 0;
    foreach (ub_tab[k]) ub_tab[k] = 0;
    foreach (ib_tab[k]) ib_tab[k] = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Extreme entries: user 1023, item 2047 zeroed, user 0 / item 0 zeroed
    users = '{0, 1023};
    items = '{0, 2047};
    foreach (users[k]) begin
      for (n = 0; n < NF; n++) send_paced(mk(MODE_WR_UF, users[k], 0, 0, n, 0));
      send_paced(mk(MODE_WR_UB, users[k], 0, 0, 0, 0));
    end
    foreach (items[k]) begin
      for (n = 0; n < NF; n++) send_paced(mk(MODE_WR_IF, 0, items[k], 0, n, 0));
      send_paced(mk(MODE_WR_IB, 0, items[k], 0, 0, 0));
    end

    // Directed table
    table_rows = {table_rows, mkw(mk(MODE_PREDICT, 0, 0, 15, 0, 0), 0, 0, 32'h000F0000)};
    table_rows = {table_rows, mkw(mk(MODE_WR_AVG, 0, 0, 0, 0, 32'h7FFFFFFF), 0, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_PREDICT, 1023, 2047, 0, 0, 0),
                                  32'h7FFFFFFF, 15, 32'h80000001)};
    table_rows = {table_rows, mkw(mk(MODE_WR_AVG, 0, 0, 0, 0, 32'h80000000), 0, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_PREDICT, 0, 2047, 15, 0, 0),
                                  32'h80000000, 0, 32'h7FFFFFFF)};
    table_rows = {table_rows, mkw(mk(MODE_WR_AVG, 0, 0, 0, 0, 32'h00028000), 0, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_PREDICT, 1023, 0, 2, 0, 0),
                                  32'h00028000, 3, 32'hFFFF8000)};
    table_rows = {table_rows,
                  mkw(mk(MODE_NOP, 1023, 2047, 15, 15, 32'hFFFFFFFF), 0, 0, 0)};
    table_rows = {table_rows, mk(MODE_TRAIN, 0, 0, 15, 0, 0)};
    table_rows = {table_rows, mk(MODE_TRAIN, 1023, 2047, 0, 15, 0)};
    table_rows = {table_rows, mkw(mk(MODE_WR_UB, 1023, 0, 0, 0, 32'h7FFFFFFF), 0, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_WR_IB, 0, 2047, 0, 0, 32'h7FFFFFFF), 0, 0, 0)};
    table_rows = {table_rows, mk(MODE_PREDICT, 1023, 2047, 7, 0, 0)};
    table_rows = {table_rows, mk(MODE_TRAIN, 1023, 2047, 7, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_WR_UF, 1023, 0, 0, 15, 32'h00010000), 0, 0, 0)};
    table_rows = {table_rows, mkw(mk(MODE_WR_IF, 0, 2047, 0, 15, 32'hFFFF0000), 0, 0, 0)};
    table_rows = {table_rows, mk(MODE_TRAIN, 1023, 2047, 3, 0, 0)};
    table_rows = {table_rows, mk(MODE_PREDICT, 1023, 2047, 3, 0, 0)};
    foreach (table_rows[k]) send_paced(table_rows[k]);
    drain_and_wait();

    // Random pool of users and items with small initial values
    for (k = 0; k < 5; k++) begin
      users = {users, int'($urandom_range(1, 1022))};
      items = {items, int'($urandom_range(1, 2046))};
    end
    foreach (users[k]) load_user(users[k], 20000);
    foreach (items[k]) load_item(items[k], 20000);
    send_paced(mk(MODE_WR_AVG, 0, 0, 0, 0, 32'h00030000));

    // Phases over register settings, extremes included
    sent = 0;
    for (ph = 0; ph < 6; ph++) begin
      drain_and_wait();
      case (ph)
        0: begin write_cfg(CFG_LEARN_RATE, 655); write_cfg(CFG_REG_WEIGHT, 655);
                 write_cfg(CFG_RATINGS, 100000); write_cfg(CFG_FACTORS, 16); end
        1: begin write_cfg(CFG_LEARN_RATE, 6554); write_cfg(CFG_REG_WEIGHT, 0);
                 write_cfg(CFG_RATINGS, 1); write_cfg(CFG_FACTORS, 1); end
        2: begin write_cfg(CFG_LEARN_RATE, 31'h7FFFFFFF);
                 write_cfg(CFG_REG_WEIGHT, 31'h7FFFFFFF);
                 write_cfg(CFG_RATINGS, 24'hFFFFFF); write_cfg(CFG_FACTORS, 0); end
        3: begin write_cfg(CFG_LEARN_RATE, 0); write_cfg(CFG_REG_WEIGHT, 3000);
                 write_cfg(CFG_RATINGS, 0); write_cfg(CFG_FACTORS, 31); end
        4: begin write_cfg(CFG_LEARN_RATE, $urandom_range(100, 20000));
                 write_cfg(CFG_REG_WEIGHT, $urandom_range(0, 20000));
                 write_cfg(CFG_RATINGS, $urandom_range(1, 1000));
                 write_cfg(CFG_FACTORS, $urandom_range(1, 16)); end
        default: begin write_cfg(CFG_LEARN_RATE, 1311); write_cfg(CFG_REG_WEIGHT, 1311);
                 write_cfg(CFG_RATINGS, 16777215); write_cfg(CFG_FACTORS, 8); end
      endcase
      cfg_we_i <= 1'b0;
      // Long receiver hold-off while the sender keeps offering
      if (ph == 1) begin
        hold_off = 1'b1;
        fork
          begin repeat (3000) @(negedge clk_i); hold_off = 1'b0; end
        join_none
      end
      for (n = 0; n < 105; n++) begin
        k = $urandom_range(0, 19);
        if (k < 12)
          s = mk(MODE_TRAIN, users[$urandom_range(0, users.size()-1)],
                 items[$urandom_range(0, items.size()-1)], $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom());
        else if (k < 16)
          s = mk(MODE_PREDICT, users[$urandom_range(0, users.size()-1)],
                 items[$urandom_range(0, items.size()-1)], $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom());
        else if (k == 16)
          s = mk(MODE_WR_UF, users[$urandom_range(0, users.size()-1)], $urandom(), 0,
                 $urandom_range(0, 15), $urandom_range(0, 80000) - 40000);
        else if (k == 17)
          s = mk(MODE_WR_IB, $urandom(), items[$urandom_range(0, items.size()-1)], 0,
                 0, $urandom_range(0, 80000) - 40000);
        else if (k == 18)
          s = mk(MODE_NOP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        else
          s = mk(MODE_WR_AVG, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 0) + ($urandom_range(0, 1) ? 32'h00030000 : $urandom()));
        send_paced(s);
        sent++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    n = 0;
    while (pending_ratings.size() != 0 && n < 400000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (300) @(negedge clk_i);
    if (errors == 0 && pending_ratings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
